/* rtl/http_host_block_filter_top_assert.svh */
// Assertion macros shared by the HTTP host filter RTL.
`ifndef HTTP_HOST_BLOCK_FILTER_TOP_ASSERT_SVH
`define HTTP_HOST_BLOCK_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define HHBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HHBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HHBF_ASSERT(lbl, prop, msg)
`define HHBF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/hhbf_pkg.sv */
// Package with beat types, parser state and constants of the HTTP host filter.
`timescale 1ns / 1ps
package hhbf_pkg;

  localparam int MAX_HOST_LEN_DEF   = 56;
  localparam int MAX_PACKET_LEN_DEF = 65535;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_WORD0 = 3'd1;

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_COMPARE = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_H  = 8'h48;

  // Tag text, first character in the top byte.
  localparam logic [47:0] HOST_TAG = "Host: ";

  // Method names padded with spaces to seven characters, first character on top.
  localparam logic [55:0] METHOD_TEXT [8] = '{
    "GET    ", "POST   ", "PUT    ", "DELETE ",
    "PATCH  ", "HEAD   ", "OPTIONS", "CONNECT"
  };
  localparam logic [2:0] METHOD_LEN [8] = '{
    3'd3, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd7, 3'd7
  };

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic drop;
    logic method_found;
    logic host_header_found;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] cand;
    logic       method_ok;
    logic [2:0] off;
    logic [2:0] search_pos;
    logic [1:0] phase;
    logic [5:0] cnt;
    logic       cmp_ok;
    logic       seen;
    logic       matched;
  } parser_t;

  localparam parser_t PARSER_RESET = '{
    cand: 8'hff, method_ok: 1'b0, off: 3'd0, search_pos: 3'd0,
    phase: PH_SEARCH, cnt: 6'd0, cmp_ok: 1'b1, seen: 1'b0, matched: 1'b0
  };

endpackage

/* rtl/http_host_block_filter_top.sv */
// The verdict beat is registered from the last packet byte held in the input stage.
// Throughput: one byte per cycle (single-pass byte parser) unless the verdict stalls.
// Four speculative parsers run over the TCP header window so that any short TCP header
// length is resolved at its length byte without a replay.
// Reset clears all packet state and sets the host length and host name registers to zero.
`timescale 1ns / 1ps
module http_host_block_filter_top
  import hhbf_pkg::*;
#(
  parameter int MaxHostLen   = MAX_HOST_LEN_DEF,
  parameter int MaxPacketLen = MAX_PACKET_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "http_host_block_filter_top_assert.svh"

  logic [5:0]              name_len;
  logic [8*MaxHostLen-1:0] host_bytes;

  hhbf_cfg_regs #(.MaxHostLen(MaxHostLen)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .name_len_o  (name_len),
    .host_bytes_o(host_bytes)
  );

  in_beat_t  s1_q;
  logic      s1_valid_q;
  logic      s1_fire;
  logic      in_accept;
  out_beat_t out_q, out_d;
  logic      out_valid_q;

  logic [15:0] idx_q, idx_d;
  logic [5:0]  ip_q, ip_d;
  logic [5:0]  tcp_q, tcp_d;
  parser_t     main_q, main_d, main_nxt;
  parser_t     lane_q [4];
  parser_t     lane_nxt [4];

  logic        proc;
  logic [7:0]  b;
  logic [5:0]  ip_eff;
  logic [6:0]  tcp_at;
  logic [15:0] win_diff;
  logic [3:0]  win_off;
  logic        in_win;
  logic        at_tcp;
  logic [5:0]  tcp_new;
  logic [5:0]  tcp_cur;
  logic        main_en;
  logic [15:0] len;
  logic        payload;

  assign s1_fire    = s1_valid_q && (!s1_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_beat_i;
    end
  end

  assign b        = s1_q.pkt_byte;
  assign proc     = s1_fire && (idx_q < 16'(MaxPacketLen));
  assign ip_eff   = (idx_q == 16'd0) ? {b[3:0], 2'b00} : ip_q;
  assign tcp_at   = {1'b0, ip_eff} + 7'd12;
  assign win_diff = idx_q - {10'd0, ip_eff};
  assign win_off  = win_diff[3:0];
  assign in_win   = (idx_q >= {10'd0, ip_eff}) && (idx_q <= {9'd0, tcp_at});
  assign at_tcp   = proc && (idx_q == {9'd0, tcp_at});
  assign tcp_new  = {b[7:4], 2'b00};
  assign tcp_cur  = at_tcp ? tcp_new : tcp_q;
  assign main_en  = proc && (idx_q > {9'd0, tcp_at}) &&
                    (idx_q >= {9'd0, {1'b0, ip_eff} + {1'b0, tcp_q}});

  for (genvar k = 0; k < 4; k++) begin : g_lane
    hhbf_byte_parser #(.MaxHostLen(MaxHostLen)) u_lane (
      .en_i        (proc && in_win && (win_off >= 4'(4 * k))),
      .byte_i      (b),
      .name_len_i  (name_len),
      .host_bytes_i(host_bytes),
      .cur_i       (lane_q[k]),
      .nxt_o       (lane_nxt[k])
    );
  end

  hhbf_byte_parser #(.MaxHostLen(MaxHostLen)) u_main (
    .en_i        (main_en),
    .byte_i      (b),
    .name_len_i  (name_len),
    .host_bytes_i(host_bytes),
    .cur_i       (main_q),
    .nxt_o       (main_nxt)
  );

  // A TCP header shorter than the window hands over the lane that began at the payload start.
  always_comb begin
    main_d = main_nxt;
    if (at_tcp && b[7:6] == 2'b00) begin
      main_d = lane_nxt[b[5:4]];
    end
  end

  assign idx_d   = proc ? idx_q + 16'd1 : idx_q;
  assign ip_d    = ip_eff;
  assign tcp_d   = tcp_cur;
  assign len     = idx_d;
  assign payload = (len > {9'd0, tcp_at}) &&
                   (len > {9'd0, {1'b0, ip_eff} + {1'b0, tcp_cur}});

  always_comb begin
    out_d.method_found      = payload && main_d.method_ok;
    out_d.host_header_found = out_d.method_found && main_d.seen;
    out_d.drop              = out_d.host_header_found && main_d.matched;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ip_q   <= '0;
      tcp_q  <= '0;
      main_q <= PARSER_RESET;
      for (int k = 0; k < 4; k++) begin
        lane_q[k] <= PARSER_RESET;
      end
    end else if (s1_fire) begin
      if (s1_q.last_byte) begin
        idx_q  <= '0;
        ip_q   <= '0;
        tcp_q  <= '0;
        main_q <= PARSER_RESET;
        for (int k = 0; k < 4; k++) begin
          lane_q[k] <= PARSER_RESET;
        end
      end else begin
        idx_q  <= idx_d;
        ip_q   <= ip_d;
        tcp_q  <= tcp_d;
        main_q <= main_d;
        for (int k = 0; k < 4; k++) begin
          lane_q[k] <= lane_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `HHBF_ASSERT(a_verdict_nested, out_valid_q |-> ((!out_q.drop || out_q.host_header_found) && (!out_q.host_header_found || out_q.method_found)), "verdict flags are inconsistent")
  `HHBF_ASSERT(a_last_gives_beat, (s1_fire && s1_q.last_byte) |=> out_valid_q, "last byte produced no verdict beat")
  `HHBF_ASSERT(a_last_clears, (s1_fire && s1_q.last_byte) |=> (idx_q == 16'd0 && tcp_q == 6'd0), "packet state not cleared after last byte")
  `HHBF_ASSERT_ALWAYS(a_stall_needs_byte, in_stall_o |-> s1_valid_q, "input stalled with an empty input stage")

endmodule

/* rtl/hhbf_cfg_regs.sv */
// Configuration register file holding the blocked host name and its length.
`timescale 1ns / 1ps
module hhbf_cfg_regs
  import hhbf_pkg::*;
#(
  parameter int MaxHostLen = MAX_HOST_LEN_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic [5:0]              name_len_o,
  output logic [8*MaxHostLen-1:0] host_bytes_o
);

  localparam int HostWords = (MaxHostLen + 7) / 8;

  logic [5:0]            name_len_q;
  logic [CFG_DATA_W-1:0] words_q [HostWords];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_len_q <= '0;
      for (int w = 0; w < HostWords; w++) begin
        words_q[w] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HOST_LEN) begin
        name_len_q <= cfg_data_i[5:0];
      end
      for (int w = 0; w < HostWords; w++) begin
        if (cfg_idx_i == CFG_HOST_WORD0 + CFG_IDX_W'(w)) begin
          words_q[w] <= cfg_data_i;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MaxHostLen; k++) begin
      host_bytes_o[8*k +: 8] = words_q[k >> 3][8*(k & 7) +: 8];
    end
  end

  assign name_len_o = name_len_q;

endmodule

/* rtl/hhbf_byte_parser.sv */
// One payload parser step: method match, Host tag search and host compare.
`timescale 1ns / 1ps
module hhbf_byte_parser
  import hhbf_pkg::*;
#(
  parameter int MaxHostLen = MAX_HOST_LEN_DEF
) (
  input  logic                    en_i,
  input  logic [7:0]              byte_i,
  input  logic [5:0]              name_len_i,
  input  logic [8*MaxHostLen-1:0] host_bytes_i,
  input  parser_t                 cur_i,
  output parser_t                 nxt_o
);

  logic       cnt_in_host;
  logic [8:0] host_base;
  logic [7:0] host_chr;
  logic [7:0] tag_chr;
  logic [2:0] mlen;
  logic [7:0] mchr;

  assign cnt_in_host = (cur_i.cnt < name_len_i) && ({1'b0, cur_i.cnt} < 7'(MaxHostLen));
  assign host_base   = cnt_in_host ? {cur_i.cnt, 3'b000} : 9'd0;
  assign host_chr    = host_bytes_i[host_base +: 8];
  assign tag_chr     = HOST_TAG[8*(5 - 32'(cur_i.search_pos)) +: 8];

  always_comb begin
    nxt_o = cur_i;
    mlen  = '0;
    mchr  = '0;
    if (en_i) begin
      if (cur_i.off != 3'd7) begin
        for (int m = 0; m < 8; m++) begin
          mlen = METHOD_LEN[m];
          mchr = METHOD_TEXT[m][8*(6 - 32'(cur_i.off)) +: 8];
          if (cur_i.cand[m] && (cur_i.off < mlen)) begin
            if (byte_i != mchr) begin
              nxt_o.cand[m] = 1'b0;
            end else if ({1'b0, cur_i.off} + 4'd1 == {1'b0, mlen}) begin
              nxt_o.method_ok = 1'b1;
            end
          end
        end
        nxt_o.off = cur_i.off + 3'd1;
      end
      case (cur_i.phase)
        PH_SEARCH: begin
          if (byte_i == 8'd0) begin
            nxt_o.phase = PH_DONE;
          end else if (byte_i == tag_chr) begin
            if (cur_i.search_pos == 3'd5) begin
              nxt_o.search_pos = '0;
              nxt_o.seen       = 1'b1;
              nxt_o.phase      = PH_COMPARE;
              nxt_o.cnt        = '0;
              nxt_o.cmp_ok     = 1'b1;
            end else begin
              nxt_o.search_pos = cur_i.search_pos + 3'd1;
            end
          end else begin
            nxt_o.search_pos = (byte_i == CHAR_H) ? 3'd1 : 3'd0;
          end
        end
        PH_COMPARE: begin
          if (byte_i == 8'd0) begin
            nxt_o.phase = PH_DONE;
          end else if (byte_i == CHAR_CR || byte_i == CHAR_LF) begin
            nxt_o.matched = cur_i.cmp_ok && (cur_i.cnt == name_len_i) &&
                            ({1'b0, name_len_i} <= 7'(MaxHostLen));
            nxt_o.phase   = PH_DONE;
          end else begin
            if (!(cnt_in_host && host_chr == byte_i)) begin
              nxt_o.cmp_ok = 1'b0;
            end
            if (cur_i.cnt != 6'd63) begin
              nxt_o.cnt = cur_i.cnt + 6'd1;
            end
          end
        end
        default: begin
          nxt_o.phase = cur_i.phase;
        end
      endcase
    end
  end

endmodule
